>>> design/tcp_connection_state_engine_defines.svh
// ---------------------------------------------------------------------------
// TCP connection state engine: assertion macros
// Shared property shorthands for the checker; clk_i and rst_ni come from
// the scope of the macro use.
// ---------------------------------------------------------------------------
`ifndef TCP_CONNECTION_STATE_ENGINE_DEFINES_SVH
`define TCP_CONNECTION_STATE_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCSE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcse: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcse: next-cycle check failed");

`endif

>>> design/tcse_pkg.sv
// ---------------------------------------------------------------------------
// tcse_pkg
// Types, codes and constants of the TCP connection state engine.
// ---------------------------------------------------------------------------
package tcse_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [31:0] LOCAL_ADDR_RST = 32'h0100_007F;
  localparam logic [31:0] ISS_RST        = 32'd1000;
  localparam logic [15:0] WIN_INIT       = 16'd4096;
  localparam logic [31:0] MSS            = 32'd1460;
  localparam logic [31:0] SSTH_INIT      = 32'd65535;
  localparam logic [31:0] TH_MIN         = 32'd2920;
  localparam logic [31:0] FR_INFLATE     = 32'd4380;
  localparam logic [15:0] SRTT_INIT      = 16'd200;
  localparam logic [15:0] RTO_INIT       = 16'd400;
  localparam logic [16:0] RTO_MIN        = 17'd200;
  localparam logic [16:0] RTO_MAX        = 17'd65535;
  localparam logic [16:0] RTO_MARGIN     = 17'd40;
  localparam logic [18:0] RTT_SAMPLE     = 19'd10;
  localparam logic [15:0] MIN_LEN        = 16'd20;
  localparam logic [7:0]  DUP_MAX        = 8'hFF;
  localparam logic [7:0]  DUP_FR         = 8'd3;

  // Flag bit positions in the flags byte.
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  // Congestion avoidance divides MSS squared by cwnd.
  localparam int DIV_BITS = 22;
  localparam logic [DIV_BITS-1:0] MSS_SQ = DIV_BITS'(1460 * 1460);

  typedef enum logic [3:0] {
    OUT_MALFORMED = 4'd0,
    OUT_NONE      = 4'd1,
    OUT_RESET     = 4'd2,
    OUT_SYN_RCVD  = 4'd3,
    OUT_SYNACK    = 4'd4,
    OUT_ACK_EST   = 4'd5,
    OUT_DUP_ACK   = 4'd6,
    OUT_FAST_RTX  = 4'd7,
    OUT_NEW_ACK   = 4'd8,
    OUT_LAST_ACK  = 4'd9,
    OUT_CLOSE_WT  = 4'd10,
    OUT_TIME_WT   = 4'd11,
    OUT_FIN_CLOSE = 4'd12,
    OUT_FULL      = 4'd13
  } outcome_e;

  typedef enum logic [3:0] {
    ST_CLOSED    = 4'd0,
    ST_LISTEN    = 4'd1,
    ST_SYNSENT   = 4'd2,
    ST_SYNRCVD   = 4'd3,
    ST_ESTAB     = 4'd4,
    ST_FINWAIT1  = 4'd5,
    ST_FINWAIT2  = 4'd6,
    ST_CLOSEWAIT = 4'd7,
    ST_CLOSING   = 4'd8,
    ST_LASTACK   = 4'd9,
    ST_TIMEWAIT  = 4'd10
  } conn_state_e;

  typedef enum logic [0:0] {
    REG_LOCAL_ADDR = 1'b0,
    REG_ISS        = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0]  st;
    logic [31:0] lip;
    logic [15:0] lport;
    logic [31:0] raddr;
    logic [15:0] rport;
  } key_t;

  typedef struct packed {
    logic [31:0] una;
    logic [31:0] snd_nxt;
    logic [31:0] rcv_nxt;
    logic [15:0] snd_wnd;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [7:0]  dup_cnt;
    logic [15:0] srtt;
    logic [15:0] rto;
  } conn_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> design/tcp_connection_state_engine.sv
// ---------------------------------------------------------------------------
// tcp_connection_state_engine
// Connection table and TCP state tracking with Reno congestion control.
// ---------------------------------------------------------------------------
// One parsed TCP header is taken when start is high and busy is low; the
// single result item appears for exactly one cycle with done_o high and
// cannot be held off, so capture it on that cycle. A malformed header is
// answered in the cycle after it is taken. Every other header walks the
// key memory one slot a cycle. If no slot is matched or opened, the result
// follows the end of the walk; else the engine reads the slot's connection
// record, updates it and writes it back, and the result follows the
// write-back. A new ACK in congestion avoidance also runs the bit-serial
// divider for MSS squared over cwnd before the write-back. For a walked
// item, busy stays high from its acceptance until its result shows, which
// also keeps a write-back from overlapping the next item's reads.
// Configuration writes land at once; issue them only while busy is low and
// no result is pending.
// ---------------------------------------------------------------------------
module tcp_connection_state_engine import tcse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // header item
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [3:0]  offset_words_i,
  input  logic [7:0]  flag_bits_i,
  input  logic [15:0] peer_window_i,
  input  logic [15:0] segment_length_i,
  // result item
  output logic        done_o,
  output logic [3:0]  outcome_o,
  output logic        slot_hit_o,
  output logic [3:0]  slot_index_o,
  output logic [3:0]  conn_state_o,
  output logic [31:0] cong_window_o,
  output logic [31:0] slow_threshold_o,
  output logic [31:0] retrans_timeout_o,
  output logic [31:0] unacked_seq_o,
  output logic [31:0] next_receive_seq_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FETCH = 6'b000100,
    S_EXEC  = 6'b001000,
    S_DIV   = 6'b010000,
    S_WRITE = 6'b100000
  } fsm_e;

  fsm_e fsm_q, fsm_d;

  // configuration
  logic [31:0] local_addr_q;
  logic [31:0] iss_q;

  // captured header
  logic [31:0] saddr_q;
  logic [15:0] sport_q;
  logic [15:0] dport_q;
  logic [31:0] seq_q;
  logic [31:0] ack_q;
  logic [7:0]  flags_q;
  logic [15:0] win_q;

  // table storage: active bits in flops, keys and records in memories
  logic [SLOTS-1:0] active_q;
  key_t             key_mem  [SLOTS];
  conn_t            data_mem [SLOTS];
  key_t             key_rd_q;
  conn_t            data_rd_q;
  logic [SLOT_W-1:0] key_raddr;

  // scan
  logic [SLOT_W:0]   scan_cnt_q;
  logic              cmp_vld_q;
  logic [SLOT_W-1:0] cmp_idx_q;
  logic              hit_found_q, free_found_q;
  logic [SLOT_W-1:0] hit_idx_q, free_idx_q;
  conn_state_e       hit_st_q;
  logic              key_match, key_free, scan_end;
  logic              scan_go, scan_create;
  logic [SLOT_W-1:0] scan_slot;
  conn_state_e       scan_st;
  outcome_e          scan_oc;

  // chosen slot and its update
  logic [SLOT_W-1:0] slot_q;
  logic              create_q;
  conn_state_e       cur_st_q;
  conn_t             cur, ent_d, ent_q;
  conn_state_e       st_d, st_new_q;
  logic              act_d, act_new_q;
  outcome_e          oc_d, oc_q;
  logic              need_div;
  logic [7:0]        dup_inc;
  logic [31:0]       half, th;
  logic [18:0]       sr7;
  logic [15:0]       srtt_n;
  logic [16:0]       rto_w, rto_c;

  // divider
  logic                div_start, div_done;
  logic [DIV_BITS-1:0] div_quo;

  // result
  logic              accept, malformed, emit;
  logic [5:0]        hlen;
  outcome_e          res_oc;
  logic              res_hit;
  logic [SLOT_W-1:0] res_slot;
  logic [3:0]        res_st;
  logic [31:0]       res_cwnd, res_ssth, res_una, res_rcv;
  logic [15:0]       res_rto;
  logic              done_q;
  outcome_e          res_oc_q;
  logic              res_hit_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [3:0]        res_st_q;
  logic [31:0]       res_cwnd_q, res_ssth_q, res_una_q, res_rcv_q;
  logic [15:0]       res_rto_q;
  logic [SLOT_W+3:0] slot_ext;

  logic flag_fin, flag_syn, flag_rst, flag_ack;

  assign flag_fin = flags_q[FLAG_FIN];
  assign flag_syn = flags_q[FLAG_SYN];
  assign flag_rst = flags_q[FLAG_RST];
  assign flag_ack = flags_q[FLAG_ACK];

  assign busy   = (fsm_q != S_IDLE);
  assign accept = start && !busy;

  // Drop headers that are too short or whose offset overruns the segment.
  assign hlen      = {offset_words_i, 2'b00};
  assign malformed = (segment_length_i < MIN_LEN) || ({10'b0, hlen} < MIN_LEN) ||
                     ({10'b0, hlen} > segment_length_i);

  // -------------------------------------------------------------------------
  // Key scan: each address is issued, then compared in the next cycle.
  // -------------------------------------------------------------------------
  assign key_raddr = scan_cnt_q[SLOT_W-1:0];
  assign key_match = active_q[cmp_idx_q] && (key_rd_q.lip == local_addr_q) &&
                     (key_rd_q.lport == dport_q) && (key_rd_q.raddr == saddr_q) &&
                     (key_rd_q.rport == sport_q);
  assign key_free  = !active_q[cmp_idx_q] || (key_rd_q.st == ST_CLOSED);
  assign scan_end  = (fsm_q == S_SCAN) && (scan_cnt_q == (SLOT_W+1)'(SLOTS)) && !cmp_vld_q;

  // An existing connection always wins; a bare SYN may open a free slot.
  always_comb begin
    scan_go     = 1'b0;
    scan_create = 1'b0;
    scan_slot   = hit_idx_q;
    scan_st     = hit_st_q;
    scan_oc     = OUT_NONE;
    if (hit_found_q) begin
      scan_go = 1'b1;
    end else if (!flag_rst && flag_syn && !flag_ack) begin
      if (free_found_q) begin
        scan_go     = 1'b1;
        scan_create = 1'b1;
        scan_slot   = free_idx_q;
        scan_st     = ST_CLOSED;
      end else begin
        scan_oc = OUT_FULL;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Segment processing on the fetched record.
  // -------------------------------------------------------------------------
  always_comb begin
    if (create_q) begin
      cur.una      = iss_q;
      cur.snd_nxt  = iss_q;
      cur.rcv_nxt  = '0;
      cur.snd_wnd  = WIN_INIT;
      cur.cwnd     = MSS;
      cur.ssthresh = SSTH_INIT;
      cur.dup_cnt  = '0;
      cur.srtt     = SRTT_INIT;
      cur.rto      = RTO_INIT;
    end else begin
      cur = data_rd_q;
    end

    dup_inc = (cur.dup_cnt != DUP_MAX) ? (cur.dup_cnt + 8'd1) : cur.dup_cnt;
    half    = {1'b0, cur.cwnd[31:1]};
    th      = (half < TH_MIN) ? TH_MIN : half;

    // srtt = (7 * srtt + sample) / 8, rto = srtt + margin, clamped
    sr7    = {cur.srtt, 3'b000} - {3'b000, cur.srtt} + RTT_SAMPLE;
    srtt_n = sr7[18:3];
    rto_w  = {1'b0, srtt_n} + RTO_MARGIN;
    if (rto_w < RTO_MIN) begin
      rto_c = RTO_MIN;
    end else if (rto_w > RTO_MAX) begin
      rto_c = RTO_MAX;
    end else begin
      rto_c = rto_w;
    end

    ent_d    = cur;
    st_d     = cur_st_q;
    act_d    = 1'b1;
    oc_d     = OUT_NONE;
    need_div = 1'b0;

    if (flag_rst) begin
      st_d  = ST_CLOSED;
      act_d = 1'b0;
      oc_d  = OUT_RESET;
    end else if (flag_syn && !flag_ack) begin
      st_d          = ST_SYNRCVD;
      ent_d.rcv_nxt = seq_q + 32'd1;
      ent_d.snd_nxt = iss_q;
      ent_d.una     = iss_q;
      oc_d          = OUT_SYN_RCVD;
    end else if (flag_syn && flag_ack) begin
      if (cur_st_q == ST_SYNSENT) begin
        st_d          = ST_ESTAB;
        ent_d.rcv_nxt = seq_q + 32'd1;
        ent_d.una     = ack_q;
        ent_d.snd_nxt = ack_q;
        oc_d          = OUT_SYNACK;
      end
    end else if (flag_ack && !flag_fin) begin
      ent_d.snd_wnd = win_q;
      case (cur_st_q)
        ST_SYNRCVD: begin
          st_d      = ST_ESTAB;
          ent_d.una = ack_q;
          oc_d      = OUT_ACK_EST;
        end
        ST_LASTACK: begin
          st_d  = ST_CLOSED;
          act_d = 1'b0;
          oc_d  = OUT_LAST_ACK;
        end
        ST_ESTAB: begin
          if (ack_q == cur.una) begin
            ent_d.dup_cnt = dup_inc;
            if (dup_inc == DUP_FR) begin
              ent_d.ssthresh = th;
              ent_d.cwnd     = sat_add(th, FR_INFLATE);
              oc_d           = OUT_FAST_RTX;
            end else begin
              if (dup_inc > DUP_FR) begin
                ent_d.cwnd = sat_add(cur.cwnd, MSS);
              end
              oc_d = OUT_DUP_ACK;
            end
          end else if (ack_q > cur.una) begin
            ent_d.srtt    = srtt_n;
            ent_d.rto     = rto_c[15:0];
            ent_d.una     = ack_q;
            ent_d.dup_cnt = '0;
            if ((cur.cwnd < cur.ssthresh) || (cur.cwnd == '0)) begin
              ent_d.cwnd = sat_add(cur.cwnd, MSS);
            end else begin
              need_div = 1'b1;
            end
            oc_d = OUT_NEW_ACK;
          end
        end
        default: ;
      endcase
    end else if (flag_fin) begin
      ent_d.rcv_nxt = seq_q + 32'd1;
      case (cur_st_q)
        ST_ESTAB: begin
          st_d = ST_CLOSEWAIT;
          oc_d = OUT_CLOSE_WT;
        end
        ST_FINWAIT1: begin
          st_d = ST_TIMEWAIT;
          oc_d = OUT_TIME_WT;
        end
        ST_FINWAIT2: begin
          st_d  = ST_CLOSED;
          act_d = 1'b0;
          oc_d  = OUT_FIN_CLOSE;
        end
        default: ;
      endcase
    end
  end

  assign div_start = (fsm_q == S_EXEC) && need_div;

  tcse_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (cur.cwnd),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE: begin
        if (accept && !malformed) begin
          fsm_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          fsm_d = scan_go ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: fsm_d = S_EXEC;
      S_EXEC:  fsm_d = need_div ? S_DIV : S_WRITE;
      S_DIV: begin
        if (div_done) begin
          fsm_d = S_WRITE;
        end
      end
      S_WRITE: fsm_d = S_IDLE;
      default: fsm_d = S_IDLE;
    endcase
  end

  // Result selection: malformed at accept, no slot at scan end, else write-back.
  always_comb begin
    emit     = 1'b0;
    res_oc   = OUT_NONE;
    res_hit  = 1'b0;
    res_slot = '0;
    res_st   = '0;
    res_cwnd = '0;
    res_ssth = '0;
    res_rto  = '0;
    res_una  = '0;
    res_rcv  = '0;
    if ((fsm_q == S_IDLE) && accept && malformed) begin
      emit   = 1'b1;
      res_oc = OUT_MALFORMED;
    end else if (scan_end && !scan_go) begin
      emit   = 1'b1;
      res_oc = scan_oc;
    end else if (fsm_q == S_WRITE) begin
      emit     = 1'b1;
      res_oc   = oc_q;
      res_hit  = 1'b1;
      res_slot = slot_q;
      res_st   = st_new_q;
      res_cwnd = ent_q.cwnd;
      res_ssth = ent_q.ssthresh;
      res_rto  = ent_q.rto;
      res_una  = ent_q.una;
      res_rcv  = ent_q.rcv_nxt;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q        <= S_IDLE;
      scan_cnt_q   <= '0;
      cmp_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      create_q     <= 1'b0;
      done_q       <= 1'b0;
      active_q     <= '0;
      local_addr_q <= LOCAL_ADDR_RST;
      iss_q        <= ISS_RST;
    end else begin
      fsm_q  <= fsm_d;
      done_q <= emit;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_LOCAL_ADDR: local_addr_q <= cfg_wdata_i;
          REG_ISS:        iss_q        <= cfg_wdata_i;
          default: ;
        endcase
      end
      case (fsm_q)
        S_IDLE: begin
          if (accept) begin
            scan_cnt_q   <= '0;
            cmp_vld_q    <= 1'b0;
            hit_found_q  <= 1'b0;
            free_found_q <= 1'b0;
          end
        end
        S_SCAN: begin
          // advance the read address until every slot has been issued
          if (scan_cnt_q != (SLOT_W+1)'(SLOTS)) begin
            scan_cnt_q <= scan_cnt_q + (SLOT_W+1)'(1);
            cmp_vld_q  <= 1'b1;
          end else begin
            cmp_vld_q <= 1'b0;
          end
          if (cmp_vld_q && key_match) begin
            hit_found_q <= 1'b1;
          end
          if (cmp_vld_q && key_free) begin
            free_found_q <= 1'b1;
          end
          if (scan_end) begin
            create_q <= scan_create;
          end
        end
        S_WRITE: active_q[slot_q] <= act_new_q;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      saddr_q <= source_address_i;
      sport_q <= source_port_i;
      dport_q <= dest_port_i;
      seq_q   <= seq_number_i;
      ack_q   <= ack_number_i;
      flags_q <= flag_bits_i;
      win_q   <= peer_window_i;
    end
    if (fsm_q == S_SCAN) begin
      cmp_idx_q <= key_raddr;
      // keep only the first match and the first free slot
      if (cmp_vld_q && key_match && !hit_found_q) begin
        hit_idx_q <= cmp_idx_q;
        hit_st_q  <= conn_state_e'(key_rd_q.st);
      end
      if (cmp_vld_q && key_free && !free_found_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (scan_end) begin
        slot_q   <= scan_slot;
        cur_st_q <= scan_st;
      end
    end
    if (fsm_q == S_EXEC) begin
      ent_q     <= ent_d;
      st_new_q  <= st_d;
      act_new_q <= act_d;
      oc_q      <= oc_d;
    end
    if ((fsm_q == S_DIV) && div_done) begin
      ent_q.cwnd <= sat_add(ent_q.cwnd, {{(32-DIV_BITS){1'b0}}, div_quo});
    end
    if (emit) begin
      res_oc_q   <= res_oc;
      res_hit_q  <= res_hit;
      res_slot_q <= res_slot;
      res_st_q   <= res_st;
      res_cwnd_q <= res_cwnd;
      res_ssth_q <= res_ssth;
      res_rto_q  <= res_rto;
      res_una_q  <= res_una;
      res_rcv_q  <= res_rcv;
    end
  end

  // Key memory: state and 4-tuple of each slot.
  always_ff @(posedge clk_i) begin
    if (fsm_q == S_WRITE) begin
      key_mem[slot_q] <= '{st: st_new_q, lip: local_addr_q, lport: dport_q,
                           raddr: saddr_q, rport: sport_q};
    end
    key_rd_q <= key_mem[key_raddr];
  end

  // Connection record memory.
  always_ff @(posedge clk_i) begin
    if (fsm_q == S_WRITE) begin
      data_mem[slot_q] <= ent_q;
    end
    data_rd_q <= data_mem[slot_q];
  end

  assign slot_ext = {4'b0000, res_slot_q};

  assign done_o             = done_q;
  assign outcome_o          = res_oc_q;
  assign slot_hit_o         = res_hit_q;
  assign slot_index_o       = slot_ext[3:0];
  assign conn_state_o       = res_st_q;
  assign cong_window_o      = res_cwnd_q;
  assign slow_threshold_o   = res_ssth_q;
  assign retrans_timeout_o  = {16'b0, res_rto_q};
  assign unacked_seq_o      = res_una_q;
  assign next_receive_seq_o = res_rcv_q;

endmodule

>>> design/tcse_div.sv
// ---------------------------------------------------------------------------
// tcse_div
// Restoring divider of MSS squared by a 32-bit cwnd, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module tcse_div import tcse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [31:0]         divisor_i,
  output logic                done_o,
  output logic [DIV_BITS-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_BITS);

  logic                run_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [31:0]         rem_q;
  logic [31:0]         dsr_q;
  logic [DIV_BITS-1:0] quo_q;
  logic [32:0]         shifted;
  logic [32:0]         rem_d;
  logic                ge;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    shifted = {rem_q, quo_q[DIV_BITS-1]};
    ge      = shifted >= {1'b0, dsr_q};
    rem_d   = ge ? (shifted - {1'b0, dsr_q}) : shifted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      quo_q <= MSS_SQ;
    end else if (run_q) begin
      rem_q <= rem_d[31:0];
      quo_q <= {quo_q[DIV_BITS-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/tcse_chk.sv
// ---------------------------------------------------------------------------
// tcse_chk
// Port-level checks of the TCP connection state engine, bound to the top.
// ---------------------------------------------------------------------------
`include "tcp_connection_state_engine_defines.svh"

module tcse_chk import tcse_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [3:0]  outcome_o,
  input logic        slot_hit_o,
  input logic [3:0]  slot_index_o,
  input logic [3:0]  conn_state_o,
  input logic [31:0] cong_window_o,
  input logic [31:0] slow_threshold_o,
  input logic [31:0] retrans_timeout_o,
  input logic [31:0] unacked_seq_o,
  input logic [31:0] next_receive_seq_o
);

  logic fields_zero;

  assign fields_zero = (slot_index_o == 4'd0) && (conn_state_o == 4'd0) &&
                       (cong_window_o == 32'd0) && (slow_threshold_o == 32'd0) &&
                       (retrans_timeout_o == 32'd0) && (unacked_seq_o == 32'd0) &&
                       (next_receive_seq_o == 32'd0);

  // A result closes its item: the engine is free when it shows.
  `TCSE_ASSERT_SAME(a_done_idle, done_o, !busy)

  // An accepted item either starts the walk or is answered at once.
  `TCSE_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done_o)

  // Without a slot every slot field reads zero.
  `TCSE_ASSERT_SAME(a_no_slot_zero, done_o && !slot_hit_o, fields_zero)

  // A dropped header never touches a slot.
  `TCSE_ASSERT_SAME(a_malformed_no_slot, done_o && outcome_o == OUT_MALFORMED, !slot_hit_o)

endmodule

bind tcp_connection_state_engine tcse_chk u_tcse_chk (.*);
